// ===== hw/rtl/babm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Burst-aware bus memory package
// Item types, command and response codes, register indexes and the byte
// mask check shared by the memory block.
// ----------------------------------------------------------------------------
package babm_pkg;

    localparam int MEM_ADDR_BITS_DEF = 16;

    localparam logic [1:0] CMD_NONE        = 2'd0;
    localparam logic [1:0] CMD_BURST_START = 2'd2;
    localparam logic [1:0] CMD_BURST_CONT  = 2'd3;

    localparam logic [1:0] RESP_IDLE  = 2'd0;
    localparam logic [1:0] RESP_OK    = 2'd1;
    localparam logic [1:0] RESP_FAULT = 2'd2;

    localparam logic [2:0] CFG_READ_LATENCY  = 3'd0;
    localparam logic [2:0] CFG_WRITE_LATENCY = 3'd1;
    localparam logic [2:0] CFG_READ_PERIOD   = 3'd2;
    localparam logic [2:0] CFG_WRITE_PERIOD  = 3'd3;
    localparam logic [2:0] CFG_BOUNDARY_BITS = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] address;
        logic [3:0]  byte_mask;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  resp_state;
        logic [31:0] read_data;
    } t_out_item;

    // A mask is usable when its set lanes form one contiguous run (or it is zero).
    function automatic logic mask_is_valid(input logic [3:0] m);
        logic ok;
        begin
            unique case (m) inside
                4'h5, 4'h9, 4'hA, 4'hB, 4'hD: ok = 1'b0;
                default:                      ok = 1'b1;
            endcase
            return ok;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/babm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module babm_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 14
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hw/rtl/burst_aware_bus_memory_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Burst-aware bus memory
// Byte memory behind a 32-bit bus with programmable wait states and burst
// tracking.
// ----------------------------------------------------------------------------
// Usage: each item is one bus cycle. An item is taken on a rising edge where
// start is high and busy is low; one item can be taken every cycle. Each
// item produces exactly one result, shown on o_result for one cycle with
// o_strobe high, after the first stage and the result register. The
// receiver cannot stall, so results simply stream out in item order.
// Storage is four byte-lane RAM banks, so a word at any byte address (with
// wrap to the memory size) touches each bank exactly once. The access is
// done on the edge that takes the item; the read bytes arrive from the
// banks in the next cycle and are rotated into the held read word there.
// After reset the banks are swept to zero, one row per cycle, over all
// 2**(MEM_ADDR_BITS-2) rows (16384 at the default size); busy is high for
// that whole sweep. Configuration writes go through the plain write port at
// any time, but should only be issued while no items are in flight.
// ----------------------------------------------------------------------------
module burst_aware_bus_memory_top
    import babm_pkg::*;
#(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_in_item  i_item,
    output logic           o_strobe,
    output t_out_item      o_result,
    input  wire logic      i_cfg_we,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_wdata
);

    // Rows per bank; a minimal memory still gets a one-bit row address.
    localparam int ROW_BITS = (MEM_ADDR_BITS > 2) ? MEM_ADDR_BITS - 2 : 1;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [ROW_BITS-1:0] r_clr_row;

    // Configuration registers.
    logic [7:0] r_rd_lat, r_wr_lat, r_rd_per, r_wr_per;
    logic [5:0] r_bnd_bits;

    // Bus state.
    logic        r_burst, n_burst;
    logic [31:0] r_last, n_last;
    logic [7:0]  r_wait, n_wait;
    logic [31:0] r_read_hold;
    logic        r_hold_pend;

    // First stage: response code and lane offset of the item just taken.
    logic        r_s1_valid;
    logic [1:0]  r_s1_resp;
    logic [1:0]  r_s1_lane;

    // Result register.
    logic        r_strobe;
    t_out_item   r_result;

    logic        w_accept;
    logic        w_access;
    logic        w_write;
    logic        w_hold_clear;
    logic        w_hold_load;
    logic [1:0]  w_resp;
    logic        w_ba;
    logic        w_st;
    logic [7:0]  w_lat;
    logic [31:0] w_bnd_mask;
    logic [31:0] w_ram_word;
    logic [31:0] w_hold;
    logic [7:0]  w_bank_q [4];

    assign busy     = (r_state == ST_CLEAR);
    assign w_accept = start && !busy;

    assign w_bnd_mask = r_bnd_bits[5] ? 32'h0 : (32'hFFFF_FFFF << r_bnd_bits[4:0]);

    // Reset sweep over the banks.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_row == {ROW_BITS{1'b1}}) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_row <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_row <= r_clr_row + 1'b1;
        end
    end

    // Configuration write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_lat   <= 8'd0;
            r_wr_lat   <= 8'd0;
            r_rd_per   <= 8'd0;
            r_wr_per   <= 8'd0;
            r_bnd_bits <= 6'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_READ_LATENCY:  r_rd_lat   <= i_cfg_wdata;
                CFG_WRITE_LATENCY: r_wr_lat   <= i_cfg_wdata;
                CFG_READ_PERIOD:   r_rd_per   <= i_cfg_wdata;
                CFG_WRITE_PERIOD:  r_wr_per   <= i_cfg_wdata;
                CFG_BOUNDARY_BITS: r_bnd_bits <= i_cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // Request decode, burst tracking and wait counter. A request that finds
    // the counter at zero accesses (a bad mask faults); else it counts down.
    always_comb begin
        n_burst      = r_burst;
        n_last       = r_last;
        n_wait       = r_wait;
        w_access     = 1'b0;
        w_write      = 1'b0;
        w_hold_clear = 1'b0;
        w_hold_load  = 1'b0;
        w_resp       = RESP_IDLE;
        w_ba         = 1'b0;
        w_st         = 1'b0;
        w_lat        = 8'd0;
        if (w_accept) begin
            if (i_item.cmd == CMD_NONE) begin
                n_burst = 1'b0;
                n_wait  = 8'd0;
            end else if (r_wait == 8'd0) begin
                if (!mask_is_valid(i_item.byte_mask)) begin
                    // Faulting request: only the held read word changes.
                    w_resp       = RESP_FAULT;
                    w_hold_clear = 1'b1;
                end else begin
                    w_access = 1'b1;
                    w_write  = (i_item.byte_mask != 4'h0);
                    w_ba     = r_burst;
                    w_st     = (i_item.cmd == CMD_BURST_START);
                    if (w_ba && i_item.cmd != CMD_BURST_CONT) begin
                        w_ba = 1'b0;
                    end
                    if (w_ba && i_item.address != r_last + 32'd4) begin
                        w_ba = 1'b0;
                        w_st = 1'b1;
                    end
                    if (w_ba && ((i_item.address ^ r_last) & w_bnd_mask) != 32'd0) begin
                        w_ba = 1'b0;
                        w_st = 1'b1;
                    end
                    if (w_write) begin
                        w_lat = w_ba ? r_wr_per : r_wr_lat;
                    end else begin
                        w_lat = w_ba ? r_rd_per : r_rd_lat;
                    end
                    n_wait  = w_lat;
                    n_burst = w_st || w_ba;
                    if (w_st || w_ba) begin
                        n_last = i_item.address;
                    end
                    w_resp       = (w_lat == 8'd0) ? RESP_OK : RESP_IDLE;
                    w_hold_clear = w_write;
                    w_hold_load  = !w_write;
                end
            end else begin
                n_wait = r_wait - 8'd1;
                w_resp = (r_wait == 8'd1) ? RESP_OK : RESP_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst <= 1'b0;
            r_last  <= 32'd0;
            r_wait  <= 8'd0;
        end else begin
            r_burst <= n_burst;
            r_last  <= n_last;
            r_wait  <= n_wait;
        end
    end

    // Byte lane banks. Bank b holds the bytes whose address is b modulo four;
    // byte k of the word (k counted from the item address) lands in bank
    // (address + k) modulo four.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [1:0]               w_k;
        logic [MEM_ADDR_BITS-1:0] w_byte_addr;
        logic [ROW_BITS-1:0]      w_row;
        logic                     w_we;
        logic [7:0]               w_wdata;
        logic [ROW_BITS-1:0]      w_ram_addr;

        assign w_k         = 2'(b) - i_item.address[1:0];
        assign w_byte_addr = i_item.address[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(w_k);
        assign w_row       = ROW_BITS'(w_byte_addr >> 2);
        assign w_we        = busy || (w_access && w_write && i_item.byte_mask[~w_k]);
        assign w_wdata     = busy ? 8'd0 : 8'(i_item.write_data >> {~w_k, 3'b000});
        assign w_ram_addr  = busy ? r_clr_row : w_row;

        babm_ram #(
            .DATA_W (8),
            .ADDR_W (ROW_BITS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_addr  (w_ram_addr),
            .i_wdata (w_wdata),
            .o_rdata (w_bank_q[b])
        );
    end

    // Rotate the bank outputs back into big-endian word order.
    for (genvar i = 0; i < 4; i++) begin : g_word
        assign w_ram_word[31-8*i -: 8] = w_bank_q[2'(r_s1_lane + 2'(i))];
    end

    // The held read word is still in the banks in the cycle after a read.
    assign w_hold = r_hold_pend ? w_ram_word : r_read_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_hold <= 32'd0;
            r_hold_pend <= 1'b0;
        end else begin
            r_hold_pend <= w_hold_load;
            r_read_hold <= w_hold_clear ? 32'd0 : w_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_strobe   <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_resp           <= w_resp;
        r_s1_lane           <= i_item.address[1:0];
        r_result.resp_state <= r_s1_resp;
        r_result.read_data  <= w_hold;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burst-aware bus memory testbench
// Drives bus cycles into the memory block through its start/busy port, keeps
// a cycle-accurate software image of the byte store, the burst tracker and
// the wait counter, and checks every result against that image as it
// streams out. The run covers several wait-state and burst-boundary setups,
// including both extremes.
// ----------------------------------------------------------------------------
module tb;
    import babm_pkg::*;

    localparam int         MEM_ADDR_BITS = MEM_ADDR_BITS_DEF;
    localparam int         CYCLE_LIMIT   = 400_000;
    localparam logic [1:0] CMD_SINGLE    = 2'd1;
    localparam logic [3:0] MASK_READ     = 4'h0;

    // Burst tracker, wait counter and held read word of the memory.
    typedef struct {
        bit        in_burst;
        bit [31:0] burst_addr;
        bit [7:0]  wait_cnt;
        bit [31:0] held_word;
    } t_bus_state;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           start       = 1'b0;
    logic           busy;
    t_in_item       i_item      = '0;
    logic           o_strobe;
    t_out_item      o_result;
    logic           i_cfg_we    = 1'b0;
    logic [2:0]     i_cfg_index = '0;
    logic [7:0]     i_cfg_wdata = '0;

    // Wait-state setup as last written to the block.
    logic [7:0]     rd_lat;
    logic [7:0]     wr_lat;
    logic [7:0]     rd_per;
    logic [7:0]     wr_per;
    logic [5:0]     bnd_bits;

    t_bus_state     mem_state;
    logic [7:0]     mem_image [0:(1 << MEM_ADDR_BITS) - 1];

    t_in_item       req_q[$];      // bus cycles waiting to be issued
    t_out_item      resp_q[$];     // responses owed by the block, oldest first
    bit             gap_en = 1'b1;
    int             mismatch_cnt = 0;
    int             cyc_cnt = 0;

    burst_aware_bus_memory_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // A byte mask is usable when it is zero or its set lanes form one run.
    // Adding the lowest set bit to such a run carries cleanly past its top.
    function automatic bit lanes_contiguous(input logic [3:0] m);
        logic [4:0] low;
        low = {1'b0, m} & (~{1'b0, m} + 5'd1);
        return (m == MASK_READ) || ((({1'b0, m} + low) & {1'b0, m}) == 5'd0);
    endfunction

    // Advances the memory state by one bus cycle and returns the response the
    // block shows for it. Without with_mem the byte store is left alone, which
    // is enough to follow the wait counter and the burst tracker.
    function automatic t_out_item bus_cycle(inout t_bus_state s, input t_in_item it,
                                            input bit with_mem);
        t_out_item                r;
        logic [31:0]              bmask;
        logic [31:0]              word;
        logic [MEM_ADDR_BITS-1:0] a;
        bit                       restart;
        bit                       is_write;
        r.resp_state = RESP_IDLE;
        r.read_data  = '0;
        restart  = 1'b0;
        is_write = (it.byte_mask != MASK_READ);
        bmask    = (bnd_bits >= 6'd32) ? 32'd0 : (32'hFFFF_FFFF << bnd_bits);
        if (it.cmd == CMD_NONE) begin
            s.in_burst = 1'b0;
            s.wait_cnt = '0;
        end else if (s.wait_cnt == 0) begin
            // A bad mask faults at once and leaves burst, counter and store alone.
            if (!lanes_contiguous(it.byte_mask)) begin
                s.held_word  = '0;
                r.resp_state = RESP_FAULT;
                return r;
            end
            if (with_mem) begin
                word = '0;
                for (int l = 0; l < 4; l++) begin
                    a = it.address[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(l);
                    if (!is_write)
                        word = {word[23:0], mem_image[a]};
                    else if (it.byte_mask[3-l])
                        mem_image[a] = it.write_data[31-8*l -: 8];
                end
                s.held_word = is_write ? 32'd0 : word;
            end
            // Only a continue to the next word inside the boundary keeps the burst.
            if (s.in_burst && it.cmd != CMD_BURST_CONT)
                s.in_burst = 1'b0;
            if (s.in_burst && it.address != s.burst_addr + 32'd4) begin
                s.in_burst = 1'b0;
                restart    = 1'b1;
            end
            if (s.in_burst && ((it.address ^ s.burst_addr) & bmask) != 32'd0) begin
                s.in_burst = 1'b0;
                restart    = 1'b1;
            end
            if (it.cmd == CMD_BURST_START)
                restart = 1'b1;
            if (is_write)
                s.wait_cnt = s.in_burst ? wr_per : wr_lat;
            else
                s.wait_cnt = s.in_burst ? rd_per : rd_lat;
            if (restart || s.in_burst) begin
                s.in_burst   = 1'b1;
                s.burst_addr = it.address;
            end
            if (s.wait_cnt == 0)
                r.resp_state = RESP_OK;
        end else begin
            // While a wait is pending the request fields are ignored.
            s.wait_cnt = s.wait_cnt - 8'd1;
            if (s.wait_cnt == 0)
                r.resp_state = RESP_OK;
        end
        r.read_data = s.held_word;
        return r;
    endfunction

    function automatic logic [31:0] pick_address();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return r;
            1:       return {r[31:16], 11'h7FF, r[4:0]};   // top of the store, wraps
            2:       return {27'h7FF_FFFF, r[4:0]};        // wraps at 2**32
            default: return {r[31:16], 9'h0, r[6:0]};     // small window, reads hit writes
        endcase
    endfunction

    function automatic logic [3:0] pick_mask();
        logic [3:0] m;
        int         roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return MASK_READ;
        do
            m = 4'($urandom_range(1, 15));
        while (lanes_contiguous(m) != (roll < 85));
        return m;
    endfunction

    function automatic t_in_item noise_item();
        t_in_item it;
        it.cmd        = ($urandom_range(0, 15) == 0) ? CMD_NONE : 2'($urandom_range(1, 3));
        it.address    = $urandom;
        it.byte_mask  = 4'($urandom);
        it.write_data = $urandom;
        return it;
    endfunction

    task automatic push_item(input logic [1:0] cmd, input logic [31:0] addr,
                             input logic [3:0] mask, input logic [31:0] data);
        t_in_item it;
        it.cmd        = cmd;
        it.address    = addr;
        it.byte_mask  = mask;
        it.write_data = data;
        req_q.push_back(it);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
    endtask

    // Writes all five registers back to back; the bus is idle meanwhile.
    task automatic program_regs(input logic [7:0] rl, input logic [7:0] wl,
                                input logic [7:0] rp, input logic [7:0] wp,
                                input logic [5:0] bb);
        rd_lat   = rl;
        wr_lat   = wl;
        rd_per   = rp;
        wr_per   = wp;
        bnd_bits = bb;
        write_reg(CFG_READ_LATENCY, rl);
        write_reg(CFG_WRITE_LATENCY, wl);
        write_reg(CFG_READ_PERIOD, rp);
        write_reg(CFG_WRITE_PERIOD, wp);
        write_reg(CFG_BOUNDARY_BITS, {2'b00, bb});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Waits until every queued cycle has been taken and answered, then lets
    // the result pipeline settle with some margin.
    task automatic drain_bus();
        while (req_q.size() != 0 || start || resp_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Queues mostly well-formed sequences: bursts that step by four bytes and
    // runs of single accesses, each access issued once the wait counter has
    // run out. A shadow copy of the tracker tells when that is, and the
    // cycles spent waiting carry random fields. Some sequences open with an
    // idle cycle, and a few beats jump, restart or turn into singles.
    task automatic run_phase(input int n_access, input int max_beats);
        t_bus_state  shadow;
        t_in_item    it;
        t_out_item   ignored;
        logic [31:0] next_addr;
        bit          singles;
        int          beats;
        shadow = mem_state;
        while (n_access > 0) begin
            if ($urandom_range(0, 9) < 7) begin
                it     = noise_item();
                it.cmd = CMD_NONE;
                ignored = bus_cycle(shadow, it, 1'b0);
                req_q.push_back(it);
            end
            beats     = $urandom_range(1, max_beats);
            singles   = ($urandom_range(0, 3) == 0);
            next_addr = pick_address();
            for (int b = 0; b < beats && n_access > 0; b++) begin
                while (shadow.wait_cnt != 0) begin
                    it = noise_item();
                    // Long waits are mostly allowed to run out.
                    if (it.cmd == CMD_NONE && shadow.wait_cnt > 4)
                        it.cmd = CMD_BURST_CONT;
                    ignored = bus_cycle(shadow, it, 1'b0);
                    req_q.push_back(it);
                end
                if (singles) begin
                    it.cmd     = CMD_SINGLE;
                    it.address = pick_address();
                end else begin
                    it.cmd     = (b == 0) ? CMD_BURST_START : CMD_BURST_CONT;
                    it.address = next_addr;
                end
                it.byte_mask  = pick_mask();
                it.write_data = $urandom;
                case ($urandom_range(0, 15))
                    0:       it.address = pick_address();
                    1:       it.cmd = CMD_SINGLE;
                    2:       it.cmd = CMD_BURST_START;
                    default: ;
                endcase
                ignored = bus_cycle(shadow, it, 1'b0);
                req_q.push_back(it);
                n_access--;
                next_addr = it.address + 32'd4;
            end
        end
    endtask

    // Driver: an item is taken on an edge where start is high and busy low.
    // It is then run through the memory image at once, which yields the
    // response the block owes for it. A held item stays on the port until
    // taken; otherwise the next one goes out unless a random gap falls here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                resp_q.push_back(bus_cycle(mem_state, i_item, 1'b1));
            end
            if (!start || !busy) begin
                if (req_q.size() != 0 && !(gap_en && $urandom_range(0, 99) < 19)) begin
                    start  <= 1'b1;
                    i_item <= req_q.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result must match the oldest owed response.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (resp_q.size() == 0) begin
                $error("unexpected result: resp_state %0d read_data %h",
                       o_result.resp_state, o_result.read_data);
                mismatch_cnt++;
            end else begin
                want = resp_q.pop_front();
                if (o_result.resp_state !== want.resp_state) begin
                    $error("resp_state: expected %0d, got %0d",
                           want.resp_state, o_result.resp_state);
                    mismatch_cnt++;
                end
                if (o_result.read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h",
                           want.read_data, o_result.read_data);
                    mismatch_cnt++;
                end
            end
        end
    end

    // The limit covers the store sweep after reset and many times the
    // slowest legal run of all phases.
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("burst_aware_bus_memory_top regression: fail");
            $finish;
        end
    end

    initial begin
        logic [5:0] bb;
        mem_state = '{default: 0};
        for (int i = 0; i < (1 << MEM_ADDR_BITS); i++)
            mem_image[i] = 8'h00;
        rd_lat   = '0;
        wr_lat   = '0;
        rd_per   = '0;
        wr_per   = '0;
        bnd_bits = 6'd32;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cycles with no wait states and no boundary. Every mask
        // value goes to one word, the bad ones included, and is read back;
        // a word at the very top of the address space wraps in the store and
        // in 32 bits; a burst steps across the 32-bit wrap and ends idle.
        program_regs(8'd0, 8'd0, 8'd0, 8'd0, 6'd32);
        for (int m = 0; m < 16; m++)
            push_item(CMD_SINGLE, 32'h0000_0020, 4'(m), $urandom);
        push_item(CMD_SINGLE, 32'h0000_0020, MASK_READ, $urandom);
        push_item(CMD_SINGLE, 32'hFFFF_FFFF, 4'hF, $urandom);
        push_item(CMD_SINGLE, 32'h0000_FFFF, MASK_READ, $urandom);
        push_item(CMD_BURST_START, 32'hFFFF_FFF8, 4'hF, $urandom);
        push_item(CMD_BURST_CONT, 32'hFFFF_FFFC, MASK_READ, $urandom);
        push_item(CMD_BURST_CONT, 32'h0000_0000, 4'h8, $urandom);
        push_item(CMD_NONE, 32'h0000_0000, MASK_READ, $urandom);
        drain_bus();

        // Short waits with a 16-byte boundary, so bursts cross it often.
        program_regs(8'd3, 8'd2, 8'd1, 8'd0, 6'd4);
        run_phase(40, 6);
        drain_bus();

        // Longest waits, and a zero boundary that ends a burst on every move.
        program_regs(8'd255, 8'd255, 8'd255, 8'd255, 6'd0);
        run_phase(2, 2);
        drain_bus();

        // Random setups. Each phase starts from a drained bus, so the sender
        // also pauses until every owed response is in. One phase runs with
        // no gaps at all.
        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 3))
                0:       bb = 6'd32;
                1:       bb = 6'($urandom_range(0, 32));
                default: bb = 6'($urandom_range(2, 6));
            endcase
            gap_en = (ph != 3);
            program_regs(8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)),
                         8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)), bb);
            run_phase(65, 8);
            drain_bus();
        end

        if (mismatch_cnt == 0) begin
            $display("burst_aware_bus_memory_top regression: pass");
        end else begin
            $display("burst_aware_bus_memory_top regression: fail");
        end
        $finish;
    end

endmodule
